// File: rtl/core/wsa_pkg.sv
// Shared types and constants for the windowed sample averager.
// Used by the channel interfaces, the controller, the datapath and the divider.
package wsa_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int TIME_W    = 32;
	localparam int SUM_W     = 24;
	localparam int LEN_W     = 8;
	localparam int DIV_CNT_W = $clog2(SUM_W + 1);

	// controller states, one-hot
	typedef enum logic [4:0] {
		S_IDLE    = 5'b00001,
		S_UPDATE  = 5'b00010,
		S_START   = 5'b00100,
		S_DIVIDE  = 5'b01000,
		S_PUBLISH = 5'b10000
	} wsa_state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic update;
		logic div_start;
		logic publish;
	} wsa_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic enabled;
		logic wrap;
		logic div_done;
		logic out_free;
	} wsa_status_t;

endpackage

// File: rtl/core/wsa_sample_if.sv
// Input channel: one sample beat with its timestamp.
// Depends on wsa_pkg for the field widths.
interface wsa_sample_if import wsa_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample;
	logic [TIME_W-1:0]   sample_time;

	modport source (output valid, output sample, output sample_time, input ready);
	modport sink   (input valid, input sample, input sample_time, output ready);
endinterface

// File: rtl/core/wsa_result_if.sv
// Output channel: one result beat with the latest average and its timestamp.
// Depends on wsa_pkg for the field widths.
interface wsa_result_if import wsa_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                average_ready;
	logic [SAMPLE_W-1:0] average_value;
	logic [TIME_W-1:0]   average_time;

	modport source (output valid, output average_ready, output average_value,
		output average_time, input ready);
	modport sink   (input valid, input average_ready, input average_value,
		input average_time, output ready);
endinterface

// File: rtl/core/windowed_sample_averager.sv
// Boxcar moving average over the last window_length samples. Each sample beat
// yields one result beat. With averaging enabled, a beat that does not close a
// window goes through capture, ring update and publish; with window_length 0
// a beat goes through capture and publish. A beat that closes the window adds
// the divide, done by the restoring divider that retires one quotient bit per
// cycle over the 24-bit sum. One sample is in work at a time; the result
// register lets the next sample be accepted while the previous result still
// waits. Writing window_length clears the window at once, without a clearing
// pass.
module windowed_sample_averager import wsa_pkg::*; #(
	parameter int MAX_WINDOW = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             window_length_we,
	input  logic [LEN_W-1:0] window_length_wdata,
	wsa_sample_if.sink       samples,
	wsa_result_if.source     results
);

	wsa_cmd_t    cmd;
	wsa_status_t status;

	wsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_ready (samples.ready),
		.status   (status),
		.cmd      (cmd)
	);

	wsa_datapath #(
		.MAX_WINDOW(MAX_WINDOW)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (window_length_we),
		.cfg_wdata         (window_length_wdata),
		.cmd               (cmd),
		.status            (status),
		.sample            (samples.sample),
		.sample_time       (samples.sample_time),
		.res_ready         (results.ready),
		.res_valid         (results.valid),
		.res_average_ready (results.average_ready),
		.res_average_value (results.average_value),
		.res_average_time  (results.average_time)
	);

endmodule

// File: rtl/core/wsa_divider.sv
// Restoring divider, one quotient bit per cycle.
// Depends on wsa_pkg.
module wsa_divider import wsa_pkg::*; #(
	parameter int CNT_W = 9
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [SUM_W-1:0]    dividend,
	input  logic [CNT_W-1:0]    divisor,
	output logic [SAMPLE_W-1:0] quotient,
	output logic                done
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0]     div_q;
	logic [CNT_W-1:0]     rem_q;
	logic [SUM_W-1:0]     quo_q;

	logic [CNT_W:0]   trial;
	logic             fits;
	logic [CNT_W-1:0] rem_next;

	// shift the next dividend bit into the partial remainder
	assign trial    = {rem_q, quo_q[SUM_W-1]};
	assign fits     = trial >= {1'b0, div_q};
	assign rem_next = fits ? CNT_W'(trial - {1'b0, div_q}) : trial[CNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(SUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[SUM_W-2:0], fits};
		end
	end

	// sum never exceeds 255 full-scale samples, so the quotient fits a sample
	assign quotient = quo_q[SAMPLE_W-1:0];
	assign done     = done_q;

endmodule

// File: rtl/core/wsa_datapath.sv
// Datapath: sample ring memory, running sum, ring position, latched average
// and result register. Depends on wsa_pkg and instantiates wsa_divider.
module wsa_datapath import wsa_pkg::*; #(
	parameter int MAX_WINDOW = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [LEN_W-1:0]    cfg_wdata,
	input  wsa_cmd_t            cmd,
	output wsa_status_t         status,
	input  logic [SAMPLE_W-1:0] sample,
	input  logic [TIME_W-1:0]   sample_time,
	input  logic                res_ready,
	output logic                res_valid,
	output logic                res_average_ready,
	output logic [SAMPLE_W-1:0] res_average_value,
	output logic [TIME_W-1:0]   res_average_time
);

	localparam int IDX_W = $clog2(MAX_WINDOW);
	localparam int CNT_W = $clog2(MAX_WINDOW + 1);

	logic [SAMPLE_W-1:0] ring_q [MAX_WINDOW];
	logic [SAMPLE_W-1:0] rd_data_q;

	logic [LEN_W-1:0]    wl_q;
	logic [IDX_W-1:0]    pos_q;
	logic                wrapped_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SAMPLE_W-1:0] avg_q;
	logic [TIME_W-1:0]   time_lat_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic [TIME_W-1:0]   time_q;
	logic                flag_q;

	logic                res_valid_q;
	logic                res_flag_q;
	logic [SAMPLE_W-1:0] res_avg_q;
	logic [TIME_W-1:0]   res_time_q;

	logic [CNT_W-1:0]    len_eff;
	logic [CNT_W-1:0]    pos_next;
	logic                wrap;
	logic [SAMPLE_W-1:0] old_sample;
	logic [SAMPLE_W-1:0] quotient;
	logic                div_done;

	// window longer than the ring is clamped to the ring size
	assign len_eff = ({1'b0, wl_q} > (LEN_W+1)'(MAX_WINDOW)) ?
		CNT_W'(MAX_WINDOW) : CNT_W'(wl_q);

	assign pos_next = CNT_W'(pos_q) + CNT_W'(1);
	assign wrap     = pos_next == len_eff;

	// until the first wrap since clearing, the slot being replaced was never written
	assign old_sample = wrapped_q ? rd_data_q : '0;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rd_data_q <= ring_q[pos_q];
			sample_q  <= sample;
			time_q    <= sample_time;
		end
		if (cmd.update) begin
			ring_q[pos_q] <= sample_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q       <= '0;
			pos_q      <= '0;
			wrapped_q  <= 1'b0;
			sum_q      <= '0;
			avg_q      <= '0;
			time_lat_q <= '0;
			flag_q     <= 1'b0;
		end else begin
			priority if (cfg_we) begin
				wl_q      <= cfg_wdata;
				pos_q     <= '0;
				wrapped_q <= 1'b0;
				sum_q     <= '0;
				avg_q     <= '0;
			end else if (cmd.capture) begin
				flag_q <= 1'b0;
			end else if (cmd.update) begin
				sum_q  <= sum_q - SUM_W'(old_sample) + SUM_W'(sample_q);
				flag_q <= wrap;
				if (wrap) begin
					pos_q      <= '0;
					wrapped_q  <= 1'b1;
					time_lat_q <= time_q;
				end else begin
					pos_q <= pos_next[IDX_W-1:0];
				end
			end else if (div_done) begin
				avg_q <= quotient;
			end else begin
				avg_q <= avg_q;
			end
		end
	end

	wsa_divider #(
		.CNT_W(CNT_W)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_q),
		.divisor  (len_eff),
		.quotient (quotient),
		.done     (div_done)
	);

	// result register frees the input side while a beat waits downstream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			res_flag_q <= flag_q;
			res_avg_q  <= avg_q;
			res_time_q <= time_lat_q;
		end
	end

	assign status.enabled  = wl_q != '0;
	assign status.wrap     = wrap;
	assign status.div_done = div_done;
	assign status.out_free = !res_valid_q || res_ready;

	assign res_valid         = res_valid_q;
	assign res_average_ready = res_flag_q;
	assign res_average_value = res_avg_q;
	assign res_average_time  = res_time_q;

endmodule

// File: rtl/core/wsa_ctrl.sv
// Controller state machine: sequences capture, ring update, divide and publish.
// Depends on wsa_pkg; drives the datapath through wsa_cmd_t.
module wsa_ctrl import wsa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  wsa_status_t status,
	output wsa_cmd_t    cmd
);

	wsa_state_t state_q;
	wsa_state_t state_next;

	assign in_ready = state_q == S_IDLE;

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					// disabled window: skip the ring update and go straight to publish
					state_next  = status.enabled ? S_UPDATE : S_PUBLISH;
				end
			end
			S_UPDATE: begin
				cmd.update = 1'b1;
				state_next = status.wrap ? S_START : S_PUBLISH;
			end
			S_START: begin
				cmd.div_start = 1'b1;
				state_next    = S_DIVIDE;
			end
			S_DIVIDE: begin
				if (status.div_done) begin
					state_next = S_PUBLISH;
				end
			end
			S_PUBLISH: begin
				if (status.out_free) begin
					cmd.publish = 1'b1;
					state_next  = S_IDLE;
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

endmodule

// File: bench/testbench.sv
// Self-checking bench for windowed_sample_averager: a directed table, then random sample
// beats under several window lengths, with results checked against an in-bench model.
// Depends on wsa_pkg, wsa_sample_if, wsa_result_if and the averager RTL.
`timescale 1ns / 1ps

module testbench import wsa_pkg::*;;

	localparam int CYCLE_LIMIT = 500000;
	localparam int DRAIN_CYCLES = 40;
	localparam int RING_DEPTH = 256;

	typedef struct packed {
		logic                rdy;
		logic [SAMPLE_W-1:0] value;
		logic [TIME_W-1:0]   stamp;
	} avg_result_t;

	typedef struct packed {
		logic                cfg_we;
		logic [LEN_W-1:0]    cfg_val;
		logic [SAMPLE_W-1:0] smp;
		logic [TIME_W-1:0]   stamp;
		logic                typed;
		avg_result_t         want;
	} stim_row_t;

	localparam int N_ROWS = 20;
	// typed rows can be read straight off the behavior; the rest go through the model
	localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
		'{1'b0, 8'd0,   16'hFFFF, 32'hFFFF_FFFF, 1'b1, '{1'b0, 16'h0000, 32'h0000_0000}},
		'{1'b0, 8'd0,   16'h0000, 32'h0000_0000, 1'b1, '{1'b0, 16'h0000, 32'h0000_0000}},
		'{1'b1, 8'd1,   16'hFFFF, 32'hFFFF_FFFF, 1'b1, '{1'b1, 16'hFFFF, 32'hFFFF_FFFF}},
		'{1'b0, 8'd0,   16'h0000, 32'h0000_0000, 1'b1, '{1'b1, 16'h0000, 32'h0000_0000}},
		'{1'b1, 8'd2,   16'hFFFF, 32'h0000_0005, 1'b1, '{1'b0, 16'h0000, 32'h0000_0000}},
		'{1'b0, 8'd0,   16'hFFFF, 32'h0000_0006, 1'b1, '{1'b1, 16'hFFFF, 32'h0000_0006}},
		'{1'b0, 8'd0,   16'h0001, 32'h0000_0007, 1'b0, '0},
		'{1'b0, 8'd0,   16'h0000, 32'h0000_0008, 1'b0, '0},
		'{1'b1, 8'd3,   16'hFFFF, 32'h0000_000A, 1'b0, '0},
		'{1'b0, 8'd0,   16'hFFFF, 32'h0000_000B, 1'b0, '0},
		'{1'b0, 8'd0,   16'hFFFF, 32'h0000_000C, 1'b1, '{1'b1, 16'hFFFF, 32'h0000_000C}},
		'{1'b1, 8'd255, 16'h1234, 32'h0000_000D, 1'b0, '0},
		'{1'b1, 8'd0,   16'hFFFF, 32'hDEAD_BEEF, 1'b1, '{1'b0, 16'h0000, 32'h0000_000C}},
		'{1'b0, 8'd0,   16'h0000, 32'h0000_0000, 1'b0, '0},
		'{1'b1, 8'd4,   16'h0001, 32'h0000_0011, 1'b0, '0},
		'{1'b0, 8'd0,   16'h0002, 32'h0000_0012, 1'b0, '0},
		'{1'b0, 8'd0,   16'h0003, 32'h0000_0013, 1'b0, '0},
		'{1'b0, 8'd0,   16'hFFFF, 32'h0000_0014, 1'b0, '0},
		'{1'b1, 8'd2,   16'h0003, 32'h0000_0015, 1'b0, '0},
		'{1'b0, 8'd0,   16'h0004, 32'h0000_0016, 1'b0, '0}
	};

	logic             clk = 1'b0;
	logic             arst_n;
	logic             window_length_we;
	logic [LEN_W-1:0] window_length_wdata;

	wsa_sample_if samples_ch();
	wsa_result_if results_ch();

	windowed_sample_averager dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.window_length_we    (window_length_we),
		.window_length_wdata (window_length_wdata),
		.samples             (samples_ch),
		.results             (results_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// model state
	logic [SAMPLE_W-1:0] window_ring [RING_DEPTH];
	int unsigned         ring_pos;
	logic [SUM_W-1:0]    window_total;
	logic [SAMPLE_W-1:0] last_average;
	logic [TIME_W-1:0]   last_stamp;
	logic [LEN_W-1:0]    window_len;

	avg_result_t pending_averages [$];
	int          idle_odds;
	int          stall_left;
	int          mismatches;
	int          beats_sent;
	int          beats_checked;
	int          averages_seen;
	int          settings_used;
	int          cycles;

	function automatic avg_result_t advance_window(logic [SAMPLE_W-1:0] smp,
		logic [TIME_W-1:0] stamp);
		avg_result_t r;
		r.rdy = 1'b0;
		if (window_len != 0) begin
			if (ring_pos >= window_len)
				ring_pos = 0;
			window_total = window_total - SUM_W'(window_ring[ring_pos]) + SUM_W'(smp);
			window_ring[ring_pos] = smp;
			ring_pos++;
			if (ring_pos == window_len) begin
				ring_pos = 0;
				last_stamp = stamp;
				last_average = SAMPLE_W'(window_total / SUM_W'(window_len));
				r.rdy = 1'b1;
			end
		end
		r.value = last_average;
		r.stamp = last_stamp;
		return r;
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_sample(bit heavy);
		int unsigned r;
		r = $urandom_range(0, 7);
		if (heavy)
			return (r < 6) ? 16'hFFFF : SAMPLE_W'($urandom());
		case (r)
			0: return 16'h0000;
			1, 2: return 16'hFFFF;
			default: return SAMPLE_W'($urandom());
		endcase
	endfunction

	function automatic logic [TIME_W-1:0] pick_stamp();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
		$display("mismatch at beat %0d: %s expected %0h got %0h", beats_checked, what, want, got);
		mismatches++;
	endtask

	// register writes only once every result is back
	task automatic load_window_length(logic [LEN_W-1:0] len);
		samples_ch.valid <= 1'b0;
		while (pending_averages.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		window_length_we    <= 1'b1;
		window_length_wdata <= len;
		@(posedge clk);
		window_length_we <= 1'b0;
		window_len = len;
		for (int i = 0; i < RING_DEPTH; i++)
			window_ring[i] = '0;
		ring_pos     = 0;
		window_total = '0;
		last_average = '0;
		settings_used++;
	endtask

	task automatic send_sample(logic [SAMPLE_W-1:0] smp, logic [TIME_W-1:0] stamp,
		bit typed, avg_result_t want);
		int          gap;
		bit          hold;
		avg_result_t got;
		gap = 0;
		if (idle_odds != 0 && $urandom_range(0, 15) < idle_odds)
			gap = $urandom_range(1, 11);
		// now and then let the whole pipeline run dry before the next beat
		hold = idle_odds != 0 && $urandom_range(0, 39) == 0 && pending_averages.size() != 0;
		if (gap > 0 || hold) begin
			samples_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
			while (hold && pending_averages.size() != 0)
				@(posedge clk);
		end
		samples_ch.valid       <= 1'b1;
		samples_ch.sample      <= smp;
		samples_ch.sample_time <= stamp;
		do
			@(posedge clk);
		while (!samples_ch.ready);
		got = advance_window(smp, stamp);
		pending_averages.push_back(typed ? want : got);
		beats_sent++;
	endtask

	// result side: random stall bursts
	initial begin
		stall_left = 0;
		results_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				results_ch.ready <= 1'b0;
				stall_left--;
			end else if (idle_odds != 0 && $urandom_range(0, 15) < idle_odds) begin
				stall_left = $urandom_range(1, 11) - 1;
				results_ch.ready <= 1'b0;
			end else begin
				results_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_results
		avg_result_t want;
		if (arst_n && results_ch.valid && results_ch.ready) begin
			if (pending_averages.size() == 0) begin
				report_mismatch("unexpected beat, average_value", '0,
					TIME_W'(results_ch.average_value));
			end else begin
				want = pending_averages.pop_front();
				if (results_ch.average_ready !== want.rdy)
					report_mismatch("average_ready", TIME_W'(want.rdy),
						TIME_W'(results_ch.average_ready));
				if (results_ch.average_value !== want.value)
					report_mismatch("average_value", TIME_W'(want.value),
						TIME_W'(results_ch.average_value));
				if (results_ch.average_time !== want.stamp)
					report_mismatch("average_time", want.stamp, results_ch.average_time);
				if (want.rdy)
					averages_seen++;
			end
			beats_checked++;
		end
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycles,
			pending_averages.size());
		$display("FAIL");
		$finish;
	end

	initial begin
		int unsigned pick;
		int unsigned len;
		int unsigned n;
		arst_n                 = 1'b0;
		window_length_we       = 1'b0;
		window_length_wdata    = '0;
		samples_ch.valid       = 1'b0;
		samples_ch.sample      = '0;
		samples_ch.sample_time = '0;
		idle_odds     = 0;
		mismatches    = 0;
		beats_sent    = 0;
		beats_checked = 0;
		averages_seen = 0;
		settings_used = 0;
		window_len    = '0;
		ring_pos      = 0;
		window_total  = '0;
		last_average  = '0;
		last_stamp    = '0;
		for (int i = 0; i < RING_DEPTH; i++)
			window_ring[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_ROWS; i++) begin
			if (DIRECTED_ROWS[i].cfg_we)
				load_window_length(DIRECTED_ROWS[i].cfg_val);
			send_sample(DIRECTED_ROWS[i].smp, DIRECTED_ROWS[i].stamp,
				DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
		end

		// widest window with mostly full-scale samples drives the sum to its top
		load_window_length(8'd255);
		idle_odds = 3;
		repeat (520) send_sample(pick_sample(1'b1), pick_stamp(), 1'b0, '0);

		while (beats_sent < 1130) begin
			pick = $urandom_range(0, 9);
			case (pick)
				0: len = 0;
				1: len = 1;
				2, 3, 4, 5: len = $urandom_range(2, 16);
				6, 7, 8: len = $urandom_range(17, 96);
				default: len = $urandom_range(97, 160);
			endcase
			if (len == 0)
				n = $urandom_range(10, 20);
			else if (len > 16)
				n = 2 * len + $urandom_range(0, 20);
			else
				n = $urandom_range(30, 80);
			case ($urandom_range(0, 2))
				0: idle_odds = 0;
				1: idle_odds = 2;
				default: idle_odds = 6;
			endcase
			load_window_length(LEN_W'(len));
			repeat (n) send_sample(pick_sample(1'b0), pick_stamp(), 1'b0, '0);
		end

		// closing stretch at full rate on both sides
		load_window_length(LEN_W'($urandom_range(2, 8)));
		idle_odds = 0;
		repeat (150) send_sample(pick_sample(1'b0), pick_stamp(), 1'b0, '0);
		samples_ch.valid <= 1'b0;

		while (pending_averages.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d sample beats under %0d window settings, %0d new averages seen",
			beats_sent, settings_used, averages_seen);
		$display("%0d result beats checked, %0d mismatches", beats_checked, mismatches);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
